[rtl/derq_pkg.sv]
// Shared types, request codes and defaults for the double-ended ring queue.
`timescale 1ns / 1ps
`default_nettype none
package derq_pkg;

	// Fixed field widths of the beats
	localparam int REQ_W  = 3;
	localparam int WORD_W = 32;
	localparam int OCC_W  = 11;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF  = 1024;
	localparam int DATA_W_DEF = 32;

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_PEEK_FRONT = 3'd4,
		REQ_PEEK_BACK  = 3'd5
	} req_code_t;

	// Request beat
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [WORD_W-1:0] push_value;
	} req_t;

	// Response beat
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              read_valid;
		logic              push_dropped;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the request beat
		logic execute;   // memory access and pointer update
		logic load_out;  // move the result into the response register
	} cmd_t;

endpackage
`default_nettype wire

[rtl/derq_dp.sv]
// Datapath of the double-ended ring queue: ring store, pointers, count, response register.
`timescale 1ns / 1ps
`default_nettype none
module derq_dp #(
	parameter int DEPTH      = derq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = derq_pkg::DATA_W_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire derq_pkg::cmd_t cmd,
	input  wire derq_pkg::req_t req_data,
	output derq_pkg::rsp_t      rsp_data
);

	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int OccW   = derq_pkg::OCC_W;
	localparam int WordW  = derq_pkg::WORD_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	derq_pkg::req_t          req_q;
	logic [AW-1:0]           head_q, tail_q;
	logic [CW-1:0]           count_q;
	logic [DATA_WIDTH-1:0]   mem [DEPTH];
	logic [DATA_WIDTH-1:0]   rd_q;
	logic                    rvalid_q, drop_q;
	logic [CW-1:0]           occ_q;
	derq_pkg::rsp_t          rsp_q;

	logic                    full, empty, is_push;
	logic [AW-1:0]           head_fwd, head_back, tail_fwd, tail_back;
	logic [AW-1:0]           head_d, tail_d, mem_addr;
	logic [CW-1:0]           count_d;
	logic                    mem_we, mem_re, rvalid_d, drop_d;

	// Ring index steps with wrap at DEPTH
	always_comb begin
		head_fwd  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
		head_back = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
		tail_fwd  = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
		tail_back = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);
	end

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign is_push = (req_q.req_type == derq_pkg::REQ_PUSH_FRONT) ||
	                 (req_q.req_type == derq_pkg::REQ_PUSH_BACK);

	// Request decode: memory access, next pointers, next count, flags
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		mem_addr = head_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rvalid_d = 1'b0;
		drop_d   = 1'b0;
		case (req_q.req_type)
			derq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					drop_d = 1'b1;
				end else begin
					head_d   = head_back;
					mem_addr = head_back;
					mem_we   = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			derq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					drop_d = 1'b1;
				end else begin
					mem_addr = tail_q;
					tail_d   = tail_fwd;
					mem_we   = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			derq_pkg::REQ_POP_FRONT: begin
				if (!empty) begin
					mem_addr = head_q;
					mem_re   = 1'b1;
					rvalid_d = 1'b1;
					head_d   = head_fwd;
					count_d  = count_q - CW'(1);
				end
			end
			derq_pkg::REQ_POP_BACK: begin
				if (!empty) begin
					tail_d   = tail_back;
					mem_addr = tail_back;
					mem_re   = 1'b1;
					rvalid_d = 1'b1;
					count_d  = count_q - CW'(1);
				end
			end
			derq_pkg::REQ_PEEK_FRONT: begin
				if (!empty) begin
					mem_addr = head_q;
					mem_re   = 1'b1;
					rvalid_d = 1'b1;
				end
			end
			derq_pkg::REQ_PEEK_BACK: begin
				if (!empty) begin
					mem_addr = tail_back;
					mem_re   = 1'b1;
					rvalid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Request register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	// Ring store, one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) begin
			mem[mem_addr] <= DATA_WIDTH'(req_q.push_value);
		end
		if (cmd.execute && mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Flags of the executed request
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rvalid_q <= rvalid_d;
			drop_q   <= drop_d;
			occ_q    <= count_d;
		end
	end

	// Response register, loaded only when the output side is free
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.read_data    <= rvalid_q ? WordW'(rd_q) : '0;
			rsp_q.read_valid   <= rvalid_q;
			rsp_q.push_dropped <= drop_q;
			rsp_q.occupancy    <= OccW'(occ_q);
			rsp_q.is_empty     <= (occ_q == '0);
		end
	end

	assign rsp_data = rsp_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count above depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty ring with head and tail apart");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && is_push && full) |=> (drop_q && $stable(count_q)))
		else $error("push into full ring not dropped");

endmodule
`default_nettype wire

[rtl/derq_ctrl.sv]
// Controller of the double-ended ring queue: request sequencing and response handshake.
`timescale 1ns / 1ps
`default_nettype none
module derq_ctrl (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output derq_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_ACCESS = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture  = 1'b0;
		cmd.execute  = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.execute = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response raised without a finished request");

endmodule
`default_nettype wire

[rtl/double_ended_ring_queue_unit.sv]
// Top level of the double-ended ring queue: controller plus datapath.
//
//   channel | direction | payload          | handshake
//   req     | in        | derq_pkg::req_t  | req_valid / req_stall
//   rsp     | out       | derq_pkg::rsp_t  | rsp_valid / rsp_stall
//
// Each request beat passes through capture, one access of the single-port
// ring store (read data registered), and the load of the response register.
// One response beat per request. A new request is taken while the previous
// response beat waits; the load waits while the response register is held.
// Reset clears pointers, fill count and handshake state; the store has no reset.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_ring_queue_unit #(
	parameter int DEPTH      = derq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = derq_pkg::DATA_W_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire derq_pkg::req_t req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output derq_pkg::rsp_t      rsp_data
);

	derq_pkg::cmd_t cmd;

	derq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	derq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

endmodule
`default_nettype wire
